[rtl/aprr_pkg.sv]
package aprr_pkg;

    localparam int ADDR_W_DEFAULT = 64;

    localparam logic [31:0] MASK_BBL    = 32'h7C00_0000;
    localparam logic [31:0] PAT_BBL     = 32'h1400_0000;
    localparam logic [31:0] MASK_BCOND  = 32'hFF00_0010;
    localparam logic [31:0] PAT_BCOND   = 32'h5400_0000;
    localparam logic [31:0] MASK_CBTB   = 32'h7E00_0000;
    localparam logic [31:0] PAT_CB      = 32'h3400_0000;
    localparam logic [31:0] PAT_TB      = 32'h3600_0000;
    localparam logic [31:0] MASK_ADR    = 32'h1F00_0000;
    localparam logic [31:0] PAT_ADR     = 32'h1000_0000;
    localparam logic [31:0] MASK_LDRLIT = 32'h3F00_0000;
    localparam logic [31:0] PAT_LDRLIT  = 32'h1800_0000;

    typedef enum logic [2:0] {
        CLS_OTHER  = 3'd0,
        CLS_BBL    = 3'd1,
        CLS_BCOND  = 3'd2,
        CLS_CB     = 3'd3,
        CLS_TB     = 3'd4,
        CLS_ADR    = 3'd5,
        CLS_ADRP   = 3'd6,
        CLS_LDRLIT = 3'd7
    } t_insn_class;

    typedef struct packed {
        t_insn_class cls;
        logic [63:0] imm;
        logic [63:0] src;
        logic [63:0] dst;
    } t_dec;

endpackage

[rtl/aprr_if.sv]
interface aprr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    logic [63:0] source_address;
    logic [63:0] dest_address;

    modport source (output valid, output instr_word, output source_address,
                    output dest_address, input ready);
    modport sink   (input valid, input instr_word, input source_address,
                    input dest_address, output ready);
endinterface

interface aprr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] relocated_word;
    logic        relocation_ok;
    logic [2:0]  insn_class;

    modport source (output valid, output relocated_word, output relocation_ok,
                    output insn_class, input ready);
    modport sink   (input valid, input relocated_word, input relocation_ok,
                    input insn_class, output ready);
endinterface

[rtl/aprr_decode.sv]
module aprr_decode (
    input  logic [31:0]   i_word,
    input  logic [63:0]   i_src,
    input  logic [63:0]   i_dst,
    output aprr_pkg::t_dec o_dec
);
    import aprr_pkg::*;

    t_insn_class cls;

    always_comb begin
        if ((i_word & MASK_BBL) == PAT_BBL) begin
            cls = CLS_BBL;
        end else if ((i_word & MASK_BCOND) == PAT_BCOND) begin
            cls = CLS_BCOND;
        end else if ((i_word & MASK_CBTB) == PAT_CB) begin
            cls = CLS_CB;
        end else if ((i_word & MASK_CBTB) == PAT_TB) begin
            cls = CLS_TB;
        end else if ((i_word & MASK_ADR) == PAT_ADR) begin
            cls = i_word[31] ? CLS_ADRP : CLS_ADR;
        end else if ((i_word & MASK_LDRLIT) == PAT_LDRLIT) begin
            cls = CLS_LDRLIT;
        end else begin
            cls = CLS_OTHER;
        end
    end

    always_comb begin
        o_dec.cls = cls;
        case (cls)
            CLS_BBL:
                o_dec.imm = {{36{i_word[25]}}, i_word[25:0], 2'b00};
            CLS_BCOND, CLS_CB, CLS_LDRLIT:
                o_dec.imm = {{43{i_word[23]}}, i_word[23:5], 2'b00};
            CLS_TB:
                o_dec.imm = {{48{i_word[18]}}, i_word[18:5], 2'b00};
            CLS_ADR:
                o_dec.imm = {{43{i_word[23]}}, i_word[23:5], i_word[30:29]};
            CLS_ADRP:
                o_dec.imm = {{31{i_word[23]}}, i_word[23:5], i_word[30:29], 12'h000};
            default:
                o_dec.imm = '0;
        endcase
        if (cls == CLS_ADRP) begin
            o_dec.src = {i_src[63:12], 12'h000};
            o_dec.dst = {i_dst[63:12], 12'h000};
        end else begin
            o_dec.src = {i_src[63:2], 2'b00};
            o_dec.dst = {i_dst[63:2], 2'b00};
        end
    end

endmodule

[rtl/aarch64_pc_relative_relocator.sv]
// Throughput: one word per cycle while the output is not stalled; four register
// stages (decode, target add, offset subtract, range check and field insert),
// each with its own valid bit, carry a word in that order to the output.
// A stalled output holds valid stages in place without loss; bubbles fill.
// Reset (synchronous, active low) clears all valid bits; payloads are not reset.
module aarch64_pc_relative_relocator #(
    parameter int ADDRESS_WIDTH = aprr_pkg::ADDR_W_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aprr_in_if.sink   i_in,
    aprr_out_if.source o_out
);
    import aprr_pkg::*;

    localparam int AW = ADDRESS_WIDTH;

    t_dec dec;

    logic en1, en2, en3, en4;

    logic          r1_valid, r2_valid, r3_valid, r4_valid;
    logic [31:0]   r1_word, r2_word, r3_word, r4_word;
    t_insn_class   r1_cls, r2_cls, r3_cls, r4_cls;
    logic [AW-1:0] r1_imm, r1_src, r1_dst;
    logic [AW-1:0] r2_target, r2_dst;
    logic [AW-1:0] r3_off;
    logic          r4_ok;

    logic [31:0]   n_word;
    logic          n_ok;
    logic [63:0]   off64;
    logic [AW-1:0] hi_b, hi_19, hi_tb, hi_adrp;
    logic          fit_b, fit_19, fit_tb, fit_adrp;

    aprr_decode u_decode (
        .i_word (i_in.instr_word),
        .i_src  (i_in.source_address),
        .i_dst  (i_in.dest_address),
        .o_dec  (dec)
    );

    assign en4 = !r4_valid || o_out.ready;
    assign en3 = !r3_valid || en4;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_in.valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_word <= i_in.instr_word;
            r1_cls  <= dec.cls;
            r1_imm  <= dec.imm[AW-1:0];
            r1_src  <= dec.src[AW-1:0];
            r1_dst  <= dec.dst[AW-1:0];
        end
        if (en2) begin
            r2_word   <= r1_word;
            r2_cls    <= r1_cls;
            r2_target <= r1_src + r1_imm;
            r2_dst    <= r1_dst;
        end
        if (en3) begin
            r3_word <= r2_word;
            r3_cls  <= r2_cls;
            r3_off  <= r2_target - r2_dst;
        end
        if (en4) begin
            r4_word <= n_word;
            r4_ok   <= n_ok;
            r4_cls  <= r3_cls;
        end
    end

    // the offset fits when every bit above the field's sign bit matches it
    assign hi_b    = $signed(r3_off) >>> 27;
    assign hi_19   = $signed(r3_off) >>> 20;
    assign hi_tb   = $signed(r3_off) >>> 15;
    assign hi_adrp = $signed(r3_off) >>> 32;
    assign fit_b    = (hi_b == '0) || (hi_b == '1);
    assign fit_19   = (hi_19 == '0) || (hi_19 == '1);
    assign fit_tb   = (hi_tb == '0) || (hi_tb == '1);
    assign fit_adrp = (hi_adrp == '0) || (hi_adrp == '1);
    assign off64    = 64'(r3_off);

    always_comb begin
        n_word = r3_word;
        n_ok   = 1'b1;
        case (r3_cls)
            CLS_BBL: begin
                n_ok = fit_b;
                if (fit_b) n_word[25:0] = off64[27:2];
            end
            CLS_BCOND, CLS_CB, CLS_LDRLIT: begin
                n_ok = fit_19;
                if (fit_19) n_word[23:5] = off64[20:2];
            end
            CLS_TB: begin
                n_ok = fit_tb;
                if (fit_tb) n_word[18:5] = off64[15:2];
            end
            CLS_ADR: begin
                n_ok = fit_19;
                if (fit_19) begin
                    n_word[30:29] = off64[1:0];
                    n_word[23:5]  = off64[20:2];
                end
            end
            CLS_ADRP: begin
                n_ok = fit_adrp;
                if (fit_adrp) begin
                    n_word[30:29] = off64[13:12];
                    n_word[23:5]  = off64[32:14];
                end
            end
            default: begin
                n_ok = 1'b1;
            end
        endcase
    end

    assign o_out.valid          = r4_valid;
    assign o_out.relocated_word = r4_word;
    assign o_out.relocation_ok  = r4_ok;
    assign o_out.insn_class     = r4_cls;

    a_other_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r4_cls == CLS_OTHER) |-> o_out.relocation_ok)
        else $error("plain word flagged as failed");

    a_adrp_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r4_cls == CLS_ADRP) |-> o_out.relocated_word[31])
        else $error("ADRP opcode bit lost in rewrite");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid straight after reset");

endmodule

[test/tb_top.sv]
module tb_top;
    import aprr_pkg::*;

    localparam int PAGE_BITS   = ADDR_W_DEFAULT - 12;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [31:0] word;
        logic        ok;
        t_insn_class cls;
    } reloc_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    aprr_in_if  in_if ();
    aprr_out_if out_if ();

    aarch64_pc_relative_relocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #6 i_clk = ~i_clk;

    reloc_t pending_relocs[$];
    reloc_t want_out;
    reloc_t want_in;
    int     mismatches      = 0;
    int     words_sent      = 0;
    int     results_checked = 0;
    int     unreachable     = 0;
    int     class_seen[8]   = '{default: 0};
    int     cycles          = 0;

    // pacing of both sides
    logic pace_free = 1'b0;
    int   gap_pct   = 30;
    int   stall_pct = 30;
    int   stall_left = 0;

    function automatic reloc_t relocate(input logic [31:0] w, input logic [63:0] src_in,
                                        input logic [63:0] dst_in);
        reloc_t      r;
        logic [63:0] src, dst, imm, off, half, sm, s, d;
        logic [31:0] fmask, nf;
        logic [20:0] imm21, n21;
        int unsigned lsb, fw;
        src   = {src_in[63:2], 2'b00};
        dst   = {dst_in[63:2], 2'b00};
        r.word = w;
        r.ok   = 1'b1;
        r.cls  = CLS_OTHER;
        lsb    = 0;
        fw     = 0;
        if ((w & MASK_BBL) == PAT_BBL) begin
            r.cls = CLS_BBL;
            fw    = 26;
        end else if ((w & MASK_BCOND) == PAT_BCOND) begin
            r.cls = CLS_BCOND;
            lsb   = 5;
            fw    = 19;
        end else if ((w & MASK_CBTB) == PAT_CB) begin
            r.cls = CLS_CB;
            lsb   = 5;
            fw    = 19;
        end else if ((w & MASK_CBTB) == PAT_TB) begin
            r.cls = CLS_TB;
            lsb   = 5;
            fw    = 14;
        end else if ((w & MASK_ADR) == PAT_ADR) begin
            r.cls = w[31] ? CLS_ADRP : CLS_ADR;
        end else if ((w & MASK_LDRLIT) == PAT_LDRLIT) begin
            r.cls = CLS_LDRLIT;
            lsb   = 5;
            fw    = 19;
        end
        if (fw != 0) begin
            fmask = (32'd1 << fw) - 32'd1;
            imm   = 64'((w >> lsb) & fmask);
            if (imm[fw-1])
                imm = imm | ~((64'd1 << fw) - 64'd1);
            imm  = imm << 2;
            off  = src + imm - dst;
            half = 64'd1 << (fw + 1);
            if (off + half < (half << 1)) begin
                nf     = off[33:2] & fmask;
                r.word = (w & ~(fmask << lsb)) | (nf << lsb);
            end else begin
                r.ok = 1'b0;
            end
        end else if (r.cls == CLS_ADR || r.cls == CLS_ADRP) begin
            imm21 = {w[23:5], w[30:29]};
            imm   = {{43{imm21[20]}}, imm21};
            if (r.cls == CLS_ADRP) begin
                s  = src >> 12;
                d  = dst >> 12;
                sm = (64'd1 << PAGE_BITS) - 64'd1;
            end else begin
                s  = src;
                d  = dst;
                sm = '1;
            end
            off = (s + imm - d) & sm;
            if (((off + (64'd1 << 20)) & sm) < (64'd1 << 21)) begin
                n21           = off[20:0];
                r.word[30:29] = n21[1:0];
                r.word[23:5]  = n21[20:2];
            end else begin
                r.ok = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic int idle_gap();
        if (pace_free || $urandom_range(0, 99) >= gap_pct)
            return 0;
        return idle_len();
    endfunction

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            out_if.ready = 1'b0;
            stall_left   = stall_left - 1;
        end else if (pace_free || $urandom_range(0, 99) >= stall_pct) begin
            out_if.ready = 1'b1;
        end else begin
            out_if.ready = 1'b0;
            stall_left   = idle_len() - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycles, pending_relocs.size());
            $display("status: fail");
            $finish;
        end
    end

    // compare results, then record accepted words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (pending_relocs.size() == 0) begin
                    $error("result word %h with nothing outstanding", out_if.relocated_word);
                    mismatches++;
                end else begin
                    want_out = pending_relocs.pop_front();
                    results_checked++;
                    if (out_if.relocated_word !== want_out.word) begin
                        $error("relocated_word: expected %h, got %h",
                               want_out.word, out_if.relocated_word);
                        mismatches++;
                    end
                    if (out_if.relocation_ok !== want_out.ok) begin
                        $error("relocation_ok: expected %0d, got %0d",
                               want_out.ok, out_if.relocation_ok);
                        mismatches++;
                    end
                    if (out_if.insn_class !== want_out.cls) begin
                        $error("insn_class: expected %0d, got %0d",
                               want_out.cls, out_if.insn_class);
                        mismatches++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                want_in = relocate(in_if.instr_word, in_if.source_address,
                                   in_if.dest_address);
                pending_relocs.push_back(want_in);
                words_sent++;
                class_seen[want_in.cls]++;
                if (!want_in.ok)
                    unreachable++;
            end
        end
    end

    task automatic send_word(input logic [31:0] w, input logic [63:0] s, input logic [63:0] d);
        int gap;
        gap = idle_gap();
        if (gap != 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.instr_word     = w;
        in_if.source_address = s;
        in_if.dest_address   = d;
        in_if.valid          = 1'b1;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (pending_relocs.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] craft_word(input t_insn_class c);
        logic [31:0] r;
        r = $urandom;
        case (c)
            CLS_BBL:    return (r & ~MASK_BBL) | PAT_BBL;
            CLS_BCOND:  return (r & ~MASK_BCOND) | PAT_BCOND;
            CLS_CB:     return (r & ~MASK_CBTB) | PAT_CB;
            CLS_TB:     return (r & ~MASK_CBTB) | PAT_TB;
            CLS_ADR:    return ((r & ~MASK_ADR) | PAT_ADR) & 32'h7FFF_FFFF;
            CLS_ADRP:   return (r & ~MASK_ADR) | PAT_ADR | 32'h8000_0000;
            CLS_LDRLIT: return (r & ~MASK_LDRLIT) | PAT_LDRLIT;
            default:    return r;
        endcase
    endfunction

    function automatic logic [31:0] offset_bits(input t_insn_class c);
        case (c)
            CLS_BBL:                     return 32'h03FF_FFFF;
            CLS_BCOND, CLS_CB, CLS_LDRLIT: return 32'h00FF_FFE0;
            CLS_TB:                      return 32'h0007_FFE0;
            CLS_ADR, CLS_ADRP:           return 32'h60FF_FFE0;
            default:                     return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [63:0] reach_of(input t_insn_class c);
        case (c)
            CLS_BBL:  return 64'd1 << 27;
            CLS_TB:   return 64'd1 << 15;
            CLS_ADRP: return 64'd1 << 32;
            default:  return 64'd1 << 20;
        endcase
    endfunction

    task automatic send_random_word();
        t_insn_class c;
        logic [31:0] w;
        logic [63:0] s, d, off, step;
        int          pick;
        c    = t_insn_class'($urandom_range(0, 7));
        w    = craft_word(c);
        s    = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 5)
            s = '0;
        else if (pick < 10)
            s = '1;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            off = 64'($urandom_range(0, 32'h000F_FFFF));
            d   = $urandom_range(0, 1) ? s + off : s - off;
        end else if (pick < 65) begin
            // zero offset field, land on the edge of reach
            w    = w & ~offset_bits(c);
            step = (c == CLS_ADRP) ? 64'd4096 : 64'd4;
            off  = reach_of(c) + step * $urandom_range(0, 8) - step * 4;
            if ($urandom_range(0, 1))
                off = -off;
            d = s - off;
            if (c == CLS_ADRP)
                d[11:0] = 12'($urandom);
        end else if (pick < 85) begin
            off = (64'd1 << $urandom_range(12, 40)) + 64'($urandom_range(0, 4095));
            d   = $urandom_range(0, 1) ? s + off : s - off;
        end else begin
            d = {$urandom, $urandom};
        end
        send_word(w, s, d);
    endtask

    task automatic test_directed_words();
        send_word(32'h0000_0000, 64'h0, 64'h0);
        send_word(32'hFFFF_FFFF, '1, '1);
        send_word(32'h15FF_FFFF, 64'h0, 64'h0);
        send_word(32'h9600_0000, 64'h0, 64'h4);
        send_word(32'h1400_0000, 64'h0800_0000, 64'h0);
        send_word(32'h1400_0000, 64'h07FF_FFFC, 64'h0);
        send_word(32'h17FF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFF0);
        send_word(32'h54FF_FFEF, 64'h1000, 64'h0010_1000);
        send_word(32'h5400_0010, 64'h0, 64'h0);
        send_word(32'h347F_FFE0, 64'h0, 64'h4);
        send_word(32'hB580_0000, 64'h0010_0000, 64'h0);
        send_word(32'h3600_0000, 64'h0, 64'h8000);
        send_word(32'hB700_0000, 64'h0, 64'h8004);
        send_word(32'h1000_0000, 64'h3, 64'h0);
        send_word(32'h70FF_FFE0, 64'h0, 64'h0010_0000);
        send_word(32'h9000_0000, 64'hFFFF_FFFF_FFFF_F000, 64'h0);
        send_word(32'h9000_0000, 64'h0, 64'h0000_0100_0000_0000);
        send_word(32'hF0FF_FFE0, 64'h0, 64'h0000_0000_FFFF_F000);
        send_word(32'h1800_0000, 64'h1000, 64'h1000);
        send_word(32'h98FF_FFE0, 64'h0, 64'h0);
        send_word(32'h5800_0000, 64'h0, 64'h8000_0000_0000_0000);
        send_word(32'h1C00_0000, 64'h0, 64'h0);
    endtask

    task automatic test_random_stream();
        repeat (1200) send_random_word();
    endtask

    task automatic test_back_to_back();
        pace_free = 1'b1;
        repeat (300) send_random_word();
        pace_free = 1'b0;
    endtask

    task automatic test_drain_then_stall();
        wait_drained();
        gap_pct   = 10;
        stall_pct = 70;
        repeat (200) send_random_word();
        gap_pct   = 30;
        stall_pct = 30;
    endtask

    initial begin
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.instr_word     = '0;
        in_if.source_address = '0;
        in_if.dest_address   = '0;
        out_if.ready         = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_words();
        test_random_stream();
        test_back_to_back();
        test_drain_then_stall();

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("%0d words relocated and checked (%0d of %0d out of reach), %0d mismatches",
                 results_checked, unreachable, words_sent, mismatches);
        $display("per class: other %0d, B/BL %0d, B.cond %0d, CB %0d, TB %0d, ADR %0d, "
                 , class_seen[0], class_seen[1], class_seen[2], class_seen[3],
                 class_seen[4], class_seen[5],
                 "ADRP %0d, LDR literal %0d", class_seen[6], class_seen[7]);
        if (mismatches == 0 && pending_relocs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
